// ===== design/i2csrs_pkg.sv =====
package i2csrs_pkg;

    localparam logic MODE_START    = 1'b0;
    localparam logic MODE_OVERFLOW = 1'b1;

    localparam logic [1:0] PH_CHECK_ADDRESS = 2'd0;
    localparam logic [1:0] PH_ACK_THEN_READ = 2'd1;
    localparam logic [1:0] PH_GET_DATA      = 2'd2;
    localparam logic [1:0] PH_ACK_FOR_READ  = 2'd3;

    localparam int ADDR_W  = 7;
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 4;

    localparam logic [BYTE_W-1:0] GENERAL_CALL = 8'h00;
    localparam logic [BYTE_W-1:0] ACK_BIT      = 8'h00;

    typedef struct packed {
        logic               listening;
        logic               drive_sda;
        logic               load_valid;
        logic [BYTE_W-1:0]  load_value;
        logic               one_bit_phase;
        logic               stored;
        logic [INDEX_W-1:0] stored_index;
        logic [BYTE_W-1:0]  stored_value;
        logic               dropped;
    } result_t;

endpackage

// ===== design/i2c_slave_receive_sequencer_core.sv =====
// Byte-level I2C slave receive sequencer. Each input item is a bus event: a
// start condition (mode 0, sda_high set when it was really a stop) or a shift
// counter overflow (mode 1) carrying the shifted byte. Every item yields one
// result item telling the bus front end whether to keep listening, whether to
// drive SDA, what to load into the shift register and whether the next
// overflow follows one bit (ACK) or eight. Address bytes, and data bytes of a
// write, are reported through stored/stored_index/stored_value; bytes beyond
// BUFFER_DEPTH raise dropped instead. The block takes one item per cycle
// while m_ready does not hold it back, set by a single input register feeding
// a single result register. An accepted item waits in the input register, and
// its result then waits in the result register on the m_ ports until m_ready
// takes it. Write own_address on the cfg channel only while no item is in flight.
module i2c_slave_receive_sequencer_core import i2csrs_pkg::*; #(
    parameter int BUFFER_DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [ADDR_W-1:0]   cfg_data,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_mode,
    input  logic [BYTE_W-1:0]   s_shift_byte,
    input  logic                s_sda_high,

    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_listening,
    output logic                m_drive_sda,
    output logic                m_load_valid,
    output logic [BYTE_W-1:0]   m_load_value,
    output logic                m_one_bit_phase,
    output logic                m_stored,
    output logic [INDEX_W-1:0]  m_stored_index,
    output logic [BYTE_W-1:0]   m_stored_value,
    output logic                m_dropped
);

    localparam int WP_W = $clog2(BUFFER_DEPTH + 1);
    localparam logic [WP_W-1:0] DEPTH_VAL = WP_W'(BUFFER_DEPTH);

    logic [ADDR_W-1:0] own_address_reg;

    logic              in_valid_reg;
    logic              in_mode_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_sda_reg;

    logic [1:0]        phase_reg;
    logic [1:0]        phase_next;
    logic              enabled_reg;
    logic              enabled_next;
    logic [WP_W-1:0]   wp_reg;
    logic [WP_W-1:0]   wp_next;

    logic              out_valid_reg;
    result_t           out_reg;
    result_t           result;

    logic              advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;

    i2csrs_step #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .WP_W         (WP_W)
    ) u_step (
        .mode                  (in_mode_reg),
        .shift_byte            (in_byte_reg),
        .sda_high              (in_sda_reg),
        .own_address           (own_address_reg),
        .phase                 (phase_reg),
        .overflow_enabled      (enabled_reg),
        .write_position        (wp_reg),
        .phase_next            (phase_next),
        .overflow_enabled_next (enabled_next),
        .write_position_next   (wp_next),
        .result                (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_address_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            own_address_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_mode_reg <= s_mode;
            in_byte_reg <= s_shift_byte;
            in_sda_reg  <= s_sda_high;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_CHECK_ADDRESS;
            enabled_reg <= 1'b0;
            wp_reg      <= '0;
        end else if (advance) begin
            phase_reg   <= phase_next;
            enabled_reg <= enabled_next;
            wp_reg      <= wp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_listening     = out_reg.listening;
    assign m_drive_sda     = out_reg.drive_sda;
    assign m_load_valid    = out_reg.load_valid;
    assign m_load_value    = out_reg.load_value;
    assign m_one_bit_phase = out_reg.one_bit_phase;
    assign m_stored        = out_reg.stored;
    assign m_stored_index  = out_reg.stored_index;
    assign m_stored_value  = out_reg.stored_value;
    assign m_dropped       = out_reg.dropped;

    assert property (@(posedge aclk) disable iff (!aresetn)
        wp_reg <= DEPTH_VAL)
        else $error("write position past buffer depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_stored && m_dropped))
        else $error("byte both stored and dropped");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_drive_sda |-> m_load_valid && m_one_bit_phase && m_listening)
        else $error("ack drive without one-bit load");

    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_mode_reg == MODE_START |=>
            wp_reg == '0 && phase_reg == PH_CHECK_ADDRESS &&
            enabled_reg == !$past(in_sda_reg))
        else $error("start did not rearm sequencer");

    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !enabled_reg && in_mode_reg == MODE_OVERFLOW |=>
            $stable(phase_reg) && $stable(wp_reg) && !enabled_reg)
        else $error("ignored overflow changed state");

endmodule

// ===== design/i2csrs_step.sv =====
module i2csrs_step import i2csrs_pkg::*; #(
    parameter int BUFFER_DEPTH = 16,
    parameter int WP_W         = 5
) (
    input  logic              mode,
    input  logic [BYTE_W-1:0] shift_byte,
    input  logic              sda_high,
    input  logic [ADDR_W-1:0] own_address,
    input  logic [1:0]        phase,
    input  logic              overflow_enabled,
    input  logic [WP_W-1:0]   write_position,
    output logic [1:0]        phase_next,
    output logic              overflow_enabled_next,
    output logic [WP_W-1:0]   write_position_next,
    output result_t           result
);

    localparam logic [WP_W-1:0] DEPTH_VAL = WP_W'(BUFFER_DEPTH);

    logic do_put;
    logic do_ack;
    logic addr_match;

    assign addr_match = (shift_byte == GENERAL_CALL) ||
                        (shift_byte[BYTE_W-1:1] == own_address);

    always_comb begin
        result                = '0;
        phase_next            = phase;
        overflow_enabled_next = overflow_enabled;
        write_position_next   = write_position;
        do_put                = 1'b0;
        do_ack                = 1'b0;

        if (mode == MODE_START) begin
            phase_next            = PH_CHECK_ADDRESS;
            write_position_next   = '0;
            overflow_enabled_next = !sda_high;
            result.listening      = !sda_high;
        end else if (overflow_enabled) begin
            unique case (phase)
                PH_CHECK_ADDRESS: begin
                    if (addr_match) begin
                        do_put     = 1'b1;
                        do_ack     = 1'b1;
                        phase_next = shift_byte[0] ? PH_ACK_FOR_READ : PH_ACK_THEN_READ;
                    end else begin
                        overflow_enabled_next = 1'b0;
                    end
                end
                PH_ACK_FOR_READ: begin
                    overflow_enabled_next = 1'b0;
                    phase_next            = PH_CHECK_ADDRESS;
                end
                PH_ACK_THEN_READ: begin
                    phase_next       = PH_GET_DATA;
                    result.listening = 1'b1;
                end
                PH_GET_DATA: begin
                    do_put     = 1'b1;
                    do_ack     = 1'b1;
                    phase_next = PH_ACK_THEN_READ;
                end
                default: begin
                    phase_next = PH_CHECK_ADDRESS;
                end
            endcase
        end

        if (do_put) begin
            if (write_position < DEPTH_VAL) begin
                result.stored       = 1'b1;
                result.stored_index = INDEX_W'(write_position);
                result.stored_value = shift_byte;
                write_position_next = write_position + 1'b1;
            end else begin
                result.dropped = 1'b1;
            end
        end

        if (do_ack) begin
            result.listening     = 1'b1;
            result.drive_sda     = 1'b1;
            result.load_valid    = 1'b1;
            result.load_value    = ACK_BIT;
            result.one_bit_phase = 1'b1;
        end
    end

endmodule
